// ===== src/framebuffer_line_draw_core_macros.svh =====
// Assertion macros shared by the line drawing core.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef FRAMEBUFFER_LINE_DRAW_CORE_MACROS_SVH
`define FRAMEBUFFER_LINE_DRAW_CORE_MACROS_SVH

// The condition must never hold outside reset.
`define FLD_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("fld assertion failed: forbidden condition seen");

// The antecedent must be followed by the consequent in the next cycle.
`define FLD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fld assertion failed: expected follow-up missing");

`endif

// ===== src/fld_pkg.sv =====
// Package for the line drawing core: field widths, defaults, command type, states.
// No dependencies.
package fld_pkg;

    localparam int COORD_W   = 7;
    localparam int RADDR_W   = 9;
    localparam int DATA_W    = 8;
    localparam int COUNT_W   = 8;
    localparam int POS_W     = COORD_W + 2;

    localparam int SCREEN_WIDTH_DEF = 84;
    localparam int BANK_COUNT_DEF   = 6;
    localparam int BANK_ROWS        = 8;

    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic               op;
        logic [RADDR_W-1:0] raddr;
        logic               set;
        logic               x_major;
        logic               xneg;
        logic               yneg;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic [COORD_W-1:0] major_len;
        logic [COORD_W-1:0] minor_len;
    } cmd_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PLOT,
        ST_MODIFY,
        ST_BYTE,
        ST_BYTE_DATA,
        ST_RESULT
    } back_state_t;

endpackage

// ===== src/framebuffer_line_draw_core.sv =====
// Line drawing core: a draw item walks each on-screen pixel through the PLOT and MODIFY
// states and each off-screen pixel through PLOT alone; a read item goes through BYTE and BYTE_DATA.
// The pixel rate is set by the read-modify-write of the frame store (one write, one registered read port).
// Reset (rst_n, asynchronous, active low) starts a clearing pass over all SCREEN_WIDTH *
// BANK_COUNT bytes (504 by default); full stays high and no item is accepted until
// it ends. Results are held in an output register, so the next item can be taken.
`include "framebuffer_line_draw_core_macros.svh"

module framebuffer_line_draw_core
    import fld_pkg::*;
#(
    parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF,
    parameter int BANK_COUNT   = BANK_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               operation,
    input  logic [COORD_W-1:0] start_x,
    input  logic [COORD_W-1:0] start_y,
    input  logic [COORD_W-1:0] end_x,
    input  logic [COORD_W-1:0] end_y,
    input  logic               draw_mode,
    input  logic [RADDR_W-1:0] read_address,
    output logic               empty,
    input  logic               pop,
    output logic [DATA_W-1:0]  read_data,
    output logic [COUNT_W-1:0] pixels_written
);

    // The front end classifies each item (direction, major axis, lengths)
    // and hands it to a two-entry queue so it keeps accepting while the
    // engine is walking a long line.
    back_status_t status;
    logic         q_full;
    logic         q_push;
    cmd_t         q_push_data;
    logic         q_pop;
    logic         q_empty;
    cmd_t         q_pop_data;
    logic         out_valid;

    fld_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .operation    (operation),
        .start_x      (start_x),
        .start_y      (start_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .draw_mode    (draw_mode),
        .read_address (read_address),
        .status       (status),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_push_data)
    );

    fld_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .q_full    (q_full),
        .pop       (q_pop),
        .q_empty   (q_empty),
        .pop_data  (q_pop_data)
    );

    // The engine owns the frame store and the result register. The result
    // register is freed by a pop in the same cycle it is refilled.
    fld_back #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .BANK_COUNT   (BANK_COUNT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_data        (q_pop_data),
        .q_pop         (q_pop),
        .status        (status),
        .out_pop       (pop && out_valid),
        .out_valid     (out_valid),
        .out_read_data (read_data),
        .out_pixels    (pixels_written)
    );

    assign empty = !out_valid;

    // No item may enter while the frame store is being cleared.
    `FLD_ASSERT_NEVER(a_no_accept_in_clear, status.clearing && !full)
    // A result is either a read byte or a pixel count, never both.
    `FLD_ASSERT_NEVER(a_one_kind, !empty && (read_data != '0) && (pixels_written != '0))
    // A line plots at most 128 pixels.
    `FLD_ASSERT_NEVER(a_count_bound, !empty && (pixels_written > COUNT_W'(128)))
    // An unpopped result stays put.
    `FLD_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(read_data) && $stable(pixels_written))

endmodule

// ===== src/fld_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 504
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/fld_front.sv =====
// Front end: accepts items, works out line direction and axis lengths.
// Depends on fld_pkg.
module fld_front
    import fld_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic                operation,
    input  logic [COORD_W-1:0]  start_x,
    input  logic [COORD_W-1:0]  start_y,
    input  logic [COORD_W-1:0]  end_x,
    input  logic [COORD_W-1:0]  end_y,
    input  logic                draw_mode,
    input  logic [RADDR_W-1:0]  read_address,
    input  back_status_t        status,
    input  logic                q_full,
    output logic                q_push,
    output cmd_t                q_data
);

    logic               valid_reg;
    logic               valid_next;
    cmd_t               cmd_reg;
    cmd_t               cmd_next;
    logic               accept;
    logic               advance;
    logic               xneg;
    logic               yneg;
    logic [COORD_W-1:0] lx;
    logic [COORD_W-1:0] ly;

    assign advance = valid_reg && !q_full;
    assign full    = status.clearing || (valid_reg && q_full);
    assign accept  = push && !full;

    always_comb
    begin
        xneg = end_x < start_x;
        yneg = end_y < start_y;
        lx   = xneg ? (start_x - end_x) : (end_x - start_x);
        ly   = yneg ? (start_y - end_y) : (end_y - start_y);

        cmd_next.op        = operation;
        cmd_next.raddr     = read_address;
        cmd_next.set       = draw_mode;
        cmd_next.x_major   = lx >= ly;
        cmd_next.xneg      = xneg;
        cmd_next.yneg      = yneg;
        cmd_next.start_x   = start_x;
        cmd_next.start_y   = start_y;
        cmd_next.end_x     = end_x;
        cmd_next.end_y     = end_y;
        cmd_next.major_len = (lx >= ly) ? lx : ly;
        cmd_next.minor_len = (lx >= ly) ? ly : lx;

        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign q_push = advance;
    assign q_data = cmd_reg;

endmodule

// ===== src/fld_queue.sv =====
// Two-entry command queue between the front end and the drawing engine.
// Depends on fld_pkg.
module fld_queue
    import fld_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic q_full,
    input  logic pop,
    output logic q_empty,
    output cmd_t pop_data
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign q_full   = count_reg == 2'd2;
    assign q_empty  = count_reg == 2'd0;
    assign do_push  = push && !q_full;
    assign do_pop   = pop && !q_empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/fld_back.sv =====
// Drawing engine: clears the frame store, walks lines pixel by pixel with a
// read-modify-write per pixel, serves byte reads and holds the result register.
// Depends on fld_pkg and fld_ram.
module fld_back
    import fld_pkg::*;
#(
    parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF,
    parameter int BANK_COUNT   = BANK_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  cmd_t               q_data,
    output logic               q_pop,
    output back_status_t       status,
    input  logic               out_pop,
    output logic               out_valid,
    output logic [DATA_W-1:0]  out_read_data,
    output logic [COUNT_W-1:0] out_pixels
);

    localparam int DEPTH = SCREEN_WIDTH * BANK_COUNT;
    localparam int AW    = $clog2(DEPTH);
    localparam int ROWS  = BANK_COUNT * BANK_ROWS;

    back_state_t        state_reg;
    back_state_t        state_next;
    cmd_t               cmd_reg;
    cmd_t               cmd_next;
    logic [AW-1:0]      clr_reg;
    logic [AW-1:0]      clr_next;
    logic [POS_W-1:0]   px_reg;
    logic [POS_W-1:0]   px_next;
    logic [POS_W-1:0]   py_reg;
    logic [POS_W-1:0]   py_next;
    logic [COORD_W-1:0] k_reg;
    logic [COORD_W-1:0] k_next;
    logic [COORD_W-1:0] rem_reg;
    logic [COORD_W-1:0] rem_next;
    logic               last_reg;
    logic               last_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [DATA_W-1:0]  byte_reg;
    logic [DATA_W-1:0]  byte_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [DATA_W-1:0]  out_data_reg;
    logic [DATA_W-1:0]  out_data_next;
    logic [COUNT_W-1:0] out_pix_reg;
    logic [COUNT_W-1:0] out_pix_next;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [DATA_W-1:0]  ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [DATA_W-1:0]  ram_rdata;

    logic               on_screen;
    logic [AW-1:0]      pix_addr;
    logic [DATA_W-1:0]  bit_mask;
    logic [DATA_W-1:0]  pix_byte;
    logic               byte_in_range;
    logic [AW-1:0]      byte_addr;
    logic               slot_free;
    logic               clr_done;
    logic [COORD_W:0]   rem_sum;
    logic               carry;
    logic [POS_W-1:0]   maj_step;
    logic [POS_W-1:0]   min_step;
    logic [POS_W-1:0]   adv_px;
    logic [POS_W-1:0]   adv_py;
    logic [COORD_W-1:0] adv_rem;
    logic [COORD_W-1:0] adv_k;
    logic               adv_last;

    fld_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Pixel geometry and byte address.
    always_comb
    begin
        on_screen = !px_reg[POS_W-1] && !py_reg[POS_W-1]
                    && (32'(px_reg[POS_W-2:0]) < SCREEN_WIDTH)
                    && (32'(py_reg[POS_W-2:0]) < ROWS);
        pix_addr  = AW'(32'(py_reg[COORD_W-1:3]) * SCREEN_WIDTH
                        + 32'(px_reg[POS_W-2:0]));
        bit_mask  = DATA_W'(1) << py_reg[2:0];
        pix_byte  = cmd_reg.set ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
        byte_in_range = 32'(cmd_reg.raddr) < DEPTH;
        byte_addr = AW'(32'(cmd_reg.raddr));
        slot_free = !out_valid_reg || out_pop;
        clr_done  = clr_reg == AW'(DEPTH - 1);
    end

    // Step along the line: the major axis moves every pixel, the minor axis
    // moves whenever the running remainder reaches or passes the major length.
    always_comb
    begin
        rem_sum  = {1'b0, rem_reg} + {1'b0, cmd_reg.minor_len};
        carry    = rem_sum >= {1'b0, cmd_reg.major_len};
        adv_rem  = carry ? COORD_W'(rem_sum - {1'b0, cmd_reg.major_len})
                         : rem_sum[COORD_W-1:0];
        adv_k    = k_reg + COORD_W'(1);
        maj_step = (cmd_reg.x_major ? cmd_reg.xneg : cmd_reg.yneg)
                   ? {POS_W{1'b1}} : POS_W'(1);
        min_step = (cmd_reg.x_major ? cmd_reg.yneg : cmd_reg.xneg)
                   ? {POS_W{1'b1}} : POS_W'(1);
        adv_last = 1'b0;
        if (k_reg == cmd_reg.major_len - COORD_W'(1))
        begin
            adv_px   = POS_W'(cmd_reg.end_x);
            adv_py   = POS_W'(cmd_reg.end_y);
            adv_last = 1'b1;
        end
        else if (cmd_reg.x_major)
        begin
            adv_px = px_reg + maj_step;
            adv_py = carry ? (py_reg + min_step) : py_reg;
        end
        else
        begin
            adv_py = py_reg + maj_step;
            adv_px = carry ? (px_reg + min_step) : px_reg;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = (q_data.op == OP_READ) ? ST_BYTE : ST_PLOT;
                end
            end
            ST_PLOT:
            begin
                if (on_screen)
                begin
                    state_next = ST_MODIFY;
                end
                else if (last_reg)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_MODIFY:
            begin
                state_next = last_reg ? ST_RESULT : ST_PLOT;
            end
            ST_BYTE:
            begin
                state_next = ST_BYTE_DATA;
            end
            ST_BYTE_DATA:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath updates.
    always_comb
    begin
        cmd_next      = cmd_reg;
        clr_next      = clr_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        k_next        = k_reg;
        rem_next      = rem_reg;
        last_next     = last_reg;
        count_next    = count_reg;
        byte_next     = byte_reg;
        out_data_next = out_data_reg;
        out_pix_next  = out_pix_reg;
        out_valid_next = out_pop ? 1'b0 : out_valid_reg;
        q_pop         = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = pix_addr;
        ram_wdata     = pix_byte;
        ram_raddr     = pix_addr;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + AW'(1);
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_data;
                    px_next    = POS_W'(q_data.start_x);
                    py_next    = POS_W'(q_data.start_y);
                    k_next     = '0;
                    rem_next   = '0;
                    last_next  = q_data.major_len == '0;
                    count_next = '0;
                end
            end
            ST_PLOT:
            begin
                if (!on_screen)
                begin
                    px_next   = adv_px;
                    py_next   = adv_py;
                    k_next    = adv_k;
                    rem_next  = adv_rem;
                    last_next = adv_last;
                end
            end
            ST_MODIFY:
            begin
                ram_we     = 1'b1;
                count_next = count_reg + COUNT_W'(1);
                px_next    = adv_px;
                py_next    = adv_py;
                k_next     = adv_k;
                rem_next   = adv_rem;
                last_next  = adv_last;
            end
            ST_BYTE:
            begin
                ram_raddr = byte_addr;
            end
            ST_BYTE_DATA:
            begin
                byte_next = byte_in_range ? ram_rdata : '0;
            end
            ST_RESULT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = (cmd_reg.op == OP_READ) ? byte_reg : '0;
                    out_pix_next   = (cmd_reg.op == OP_READ) ? '0 : count_reg;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        k_reg        <= k_next;
        rem_reg      <= rem_next;
        last_reg     <= last_next;
        count_reg    <= count_next;
        byte_reg     <= byte_next;
        out_data_reg <= out_data_next;
        out_pix_reg  <= out_pix_next;
    end

    assign status.clearing = state_reg == ST_CLEAR;
    assign out_valid       = out_valid_reg;
    assign out_read_data   = out_data_reg;
    assign out_pixels      = out_pix_reg;

endmodule
